// ===== sv/multi_channel_soft_timer_table_macros.svh =====
// Assertion macros shared by the timer table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MULTI_CHANNEL_SOFT_TIMER_TABLE_MACROS_SVH
`define MULTI_CHANNEL_SOFT_TIMER_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, held off during reset
`define MCTT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check, also active during reset
`define MCTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCTT_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCTT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/mctt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the timer table.
// No dependencies.
package mctt_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int PTR_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = 6;

  // actions
  localparam logic [3:0] ACT_CREATE  = 4'd0;
  localparam logic [3:0] ACT_DESTROY = 4'd1;
  localparam logic [3:0] ACT_START   = 4'd2;
  localparam logic [3:0] ACT_STOP    = 4'd3;
  localparam logic [3:0] ACT_PAUSE   = 4'd4;
  localparam logic [3:0] ACT_RESUME  = 4'd5;
  localparam logic [3:0] ACT_SETIVL  = 4'd6;
  localparam logic [3:0] ACT_TICK    = 4'd7;
  localparam logic [3:0] ACT_QUERY   = 4'd8;

  // result status
  localparam logic [1:0] E_OK       = 2'd0;
  localparam logic [1:0] E_FULL     = 2'd1;
  localparam logic [1:0] E_NOTFOUND = 2'd2;
  localparam logic [1:0] E_INVALID  = 2'd3;

  // timer states
  localparam logic [1:0] TS_STOPPED = 2'd0;
  localparam logic [1:0] TS_RUNNING = 2'd1;
  localparam logic [1:0] TS_PAUSED  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DIV,
    S_FIRE,
    S_SUM
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic fire;
    logic summary;
    logic ptr_inc;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic hit;
    logic need_div;
    logic div_done;
    logic ptr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/multi_channel_soft_timer_table.sv =====
// Top level of the timer table: controller plus datapath.
// Depends on mctt_pkg, mctt_ctrl, mctt_dp.
// One transaction is processed at a time. A non-tick action's result is loaded into the output
// register from the exec state once the result register is free. A tick walks the NUM_TIMERS
// slots one per cycle while no timer fires; each fired periodic timer first waits on the
// bit-serial remainder unit that realigns its start time, and each fired timer's result is
// loaded once the result side does not stall. The next item is accepted the cycle after the
// last result of the previous one is loaded into the output register.
module multi_channel_soft_timer_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [7:0]  in_timer_id,
  input  logic [31:0] in_interval,
  input  logic        in_periodic,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot_id,
  output logic        out_fired,
  output logic [5:0]  out_fired_in_tick,
  output logic [1:0]  out_timer_state,
  output logic [31:0] out_remaining,
  output logic [31:0] out_timer_fires,
  output logic [31:0] out_all_fires,
  output logic [31:0] out_all_ticks,
  output logic [5:0]  out_used_slots,
  output logic        out_last
);

  mctt_pkg::cmd_t cmd;
  mctt_pkg::sts_t sts;

  mctt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mctt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_action),
    .in_timer_id       (in_timer_id),
    .in_interval       (in_interval),
    .in_periodic       (in_periodic),
    .in_now            (in_now),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot_id       (out_slot_id),
    .out_fired         (out_fired),
    .out_fired_in_tick (out_fired_in_tick),
    .out_timer_state   (out_timer_state),
    .out_remaining     (out_remaining),
    .out_timer_fires   (out_timer_fires),
    .out_all_fires     (out_all_fires),
    .out_all_ticks     (out_all_ticks),
    .out_used_slots    (out_used_slots),
    .out_last          (out_last)
  );

endmodule

// ===== sv/mctt_div.sv =====
// Bit-serial restoring divider, remainder only, one quotient bit per cycle.
// No package dependencies.
module mctt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] shifted;
  logic [32:0] trial;

  // one restoring step
  always_comb begin
    shifted  = {rem_r, dvd_r[31]};
    trial    = shifted - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = trial[32] ? shifted[31:0] : trial[31:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== sv/mctt_dp.sv =====
// Datapath: slot table, counters, input latch, result register, divider.
// Depends on mctt_pkg, mctt_div and the assertion macro header.
`include "multi_channel_soft_timer_table_macros.svh"
module mctt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          in_action,
  input  logic [7:0]          in_timer_id,
  input  logic [31:0]         in_interval,
  input  logic                in_periodic,
  input  logic [31:0]         in_now,
  input  mctt_pkg::cmd_t      cmd,
  output mctt_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [7:0]          out_slot_id,
  output logic                out_fired,
  output logic [5:0]          out_fired_in_tick,
  output logic [1:0]          out_timer_state,
  output logic [31:0]         out_remaining,
  output logic [31:0]         out_timer_fires,
  output logic [31:0]         out_all_fires,
  output logic [31:0]         out_all_ticks,
  output logic [5:0]          out_used_slots,
  output logic                out_last
);

  localparam int N  = mctt_pkg::NUM_TIMERS;
  localparam int PW = mctt_pkg::PTR_W;
  localparam int CW = mctt_pkg::CNT_W;

  // latched transaction
  logic [3:0]  act_r;
  logic [7:0]  id_r;
  logic [31:0] ival_r;
  logic        per_r;
  logic [31:0] now_r;
  logic [PW-1:0] ptr_r;
  logic [CW-1:0] fcnt_r;
  logic [31:0] tot_fires_r, tot_ticks_r;

  // slot table
  logic [N-1:0] used_r;
  logic [N-1:0] sper_r;
  logic [1:0]   sst_r    [N];
  logic [31:0]  sivl_r   [N];
  logic [31:0]  sstart_r [N];
  logic [31:0]  srem_r   [N];
  logic [31:0]  sfires_r [N];

  // result register
  logic        ov_r;
  logic [1:0]  o_status_r;
  logic [7:0]  o_slot_r;
  logic        o_fired_r;
  logic [5:0]  o_nfired_r;
  logic [1:0]  o_tstate_r;
  logic [31:0] o_rem_r;
  logic [31:0] o_tfires_r;
  logic [31:0] o_afires_r;
  logic [31:0] o_aticks_r;
  logic [5:0]  o_used_r;
  logic        o_last_r;

  // divider
  logic        div_done;
  logic [31:0] div_rem;

  // current slot view
  logic        c_used, c_per;
  logic [1:0]  c_st;
  logic [31:0] c_ivl, c_start, c_rem, c_fires, elapsed, rem_of;
  logic        expired;

  always_comb begin
    c_used  = used_r[ptr_r];
    c_per   = sper_r[ptr_r];
    c_st    = sst_r[ptr_r];
    c_ivl   = sivl_r[ptr_r];
    c_start = sstart_r[ptr_r];
    c_rem   = srem_r[ptr_r];
    c_fires = sfires_r[ptr_r];
    elapsed = now_r - c_start;
    expired = (elapsed >= c_ivl);
    if (c_st == mctt_pkg::TS_PAUSED)       rem_of = c_rem;
    else if (c_st == mctt_pkg::TS_RUNNING) rem_of = expired ? 32'd0 : c_ivl - elapsed;
    else                                   rem_of = 32'd0;
  end

  // lowest free slot
  logic          free_found;
  logic [PW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = PW'(i);
      end
    end
  end

  // non-tick action evaluation
  logic          wr_en;
  logic [PW-1:0] widx;
  logic          n_used, n_per;
  logic [1:0]    n_st;
  logic [31:0]   n_ivl, n_start, n_rem, n_fires;
  logic [1:0]    ex_status, ex_qst;
  logic [7:0]    ex_slot;
  logic [31:0]   ex_qrem, ex_qfires;
  logic          id_ok;

  always_comb begin
    id_ok     = (id_r < 8'(N)) && c_used;
    wr_en     = 1'b0;
    widx      = ptr_r;
    n_used    = c_used;
    n_per     = c_per;
    n_st      = c_st;
    n_ivl     = c_ivl;
    n_start   = c_start;
    n_rem     = c_rem;
    n_fires   = c_fires;
    ex_status = mctt_pkg::E_OK;
    ex_slot   = id_r;
    ex_qst    = mctt_pkg::TS_STOPPED;
    ex_qrem   = '0;
    ex_qfires = '0;
    if (act_r == mctt_pkg::ACT_CREATE) begin
      ex_slot = '0;
      if (ival_r == 32'd0) begin
        ex_status = mctt_pkg::E_INVALID;
      end else if (!free_found) begin
        ex_status = mctt_pkg::E_FULL;
      end else begin
        wr_en   = 1'b1;
        widx    = free_idx;
        n_used  = 1'b1;
        n_per   = per_r;
        n_st    = mctt_pkg::TS_STOPPED;
        n_ivl   = ival_r;
        n_start = '0;
        n_rem   = '0;
        n_fires = '0;
        ex_slot = 8'(free_idx);
      end
    end else if (act_r > mctt_pkg::ACT_QUERY) begin
      ex_status = mctt_pkg::E_INVALID;
    end else if (!id_ok) begin
      ex_status = mctt_pkg::E_NOTFOUND;
    end else begin
      case (act_r)
        mctt_pkg::ACT_DESTROY: begin
          wr_en   = 1'b1;
          n_used  = 1'b0;
          n_per   = 1'b0;
          n_st    = mctt_pkg::TS_STOPPED;
          n_ivl   = '0;
          n_start = '0;
          n_rem   = '0;
          n_fires = '0;
        end
        mctt_pkg::ACT_START: begin
          wr_en   = 1'b1;
          n_start = now_r;
          n_rem   = '0;
          n_st    = mctt_pkg::TS_RUNNING;
        end
        mctt_pkg::ACT_STOP: begin
          wr_en = 1'b1;
          n_st  = mctt_pkg::TS_STOPPED;
          n_rem = '0;
        end
        mctt_pkg::ACT_PAUSE: begin
          if (c_st != mctt_pkg::TS_RUNNING) begin
            ex_status = mctt_pkg::E_INVALID;
          end else begin
            wr_en = 1'b1;
            n_rem = rem_of;
            n_st  = mctt_pkg::TS_PAUSED;
          end
        end
        mctt_pkg::ACT_RESUME: begin
          if (c_st != mctt_pkg::TS_PAUSED) begin
            ex_status = mctt_pkg::E_INVALID;
          end else begin
            wr_en   = 1'b1;
            n_start = now_r - (c_ivl - c_rem);
            n_st    = mctt_pkg::TS_RUNNING;
          end
        end
        mctt_pkg::ACT_SETIVL: begin
          if (ival_r == 32'd0) begin
            ex_status = mctt_pkg::E_INVALID;
          end else begin
            wr_en = 1'b1;
            n_ivl = ival_r;
            if (c_st == mctt_pkg::TS_RUNNING) begin
              n_start = now_r;
              n_rem   = '0;
            end else if (c_st == mctt_pkg::TS_PAUSED) begin
              n_rem = ival_r;
            end else begin
              n_rem = '0;
            end
          end
        end
        mctt_pkg::ACT_QUERY: begin
          ex_qst    = c_st;
          ex_qrem   = rem_of;
          ex_qfires = c_fires;
        end
        default: begin
          ex_status = mctt_pkg::E_INVALID;
        end
      endcase
    end
  end

  // allocated slot count after the action
  logic [N-1:0]  used_after;
  logic [CW-1:0] used_cnt;
  always_comb begin
    used_after = used_r;
    if (cmd.exec && wr_en) used_after[widx] = n_used;
    used_cnt = '0;
    for (int i = 0; i < N; i++) used_cnt = used_cnt + CW'(used_after[i]);
  end

  // fire update of the scanned slot
  logic [31:0] f_fires, f_start, tf_nxt;
  logic [1:0]  f_st;
  always_comb begin
    f_fires = c_fires + 32'd1;
    f_st    = c_per ? c_st : mctt_pkg::TS_STOPPED;
    f_start = (c_per && c_ivl != 32'd0) ? now_r - div_rem : c_start;
    tf_nxt  = tot_fires_r + 32'd1;
  end

  // status to controller
  always_comb begin
    sts.is_tick  = (act_r == mctt_pkg::ACT_TICK);
    sts.hit      = c_used && (c_st == mctt_pkg::TS_RUNNING) && expired;
    sts.need_div = c_per && (c_ivl != 32'd0);
    sts.div_done = div_done;
    sts.ptr_last = (ptr_r == PW'(N - 1));
    sts.out_free = !ov_r || !out_stall;
  end

  mctt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (elapsed),
    .divisor   (c_ivl),
    .done      (div_done),
    .remainder (div_rem)
  );

  // transaction latch, scan pointer, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      fcnt_r      <= '0;
      tot_fires_r <= '0;
      tot_ticks_r <= '0;
    end else begin
      if (cmd.load) begin
        ptr_r  <= (in_action == mctt_pkg::ACT_TICK) ? '0 : in_timer_id[PW-1:0];
        fcnt_r <= '0;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + PW'(1);
      end
      if (cmd.fire) begin
        fcnt_r      <= fcnt_r + CW'(1);
        tot_fires_r <= tf_nxt;
      end
      if (cmd.summary) tot_ticks_r <= tot_ticks_r + 32'd1;
    end
    if (cmd.load) begin
      act_r  <= in_action;
      id_r   <= in_timer_id;
      ival_r <= in_interval;
      per_r  <= in_periodic;
      now_r  <= in_now;
    end
  end

  // slot table writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      sper_r <= '0;
      for (int i = 0; i < N; i++) begin
        sst_r[i]    <= mctt_pkg::TS_STOPPED;
        sivl_r[i]   <= '0;
        sstart_r[i] <= '0;
        srem_r[i]   <= '0;
        sfires_r[i] <= '0;
      end
    end else if (cmd.exec && wr_en) begin
      used_r[widx]   <= n_used;
      sper_r[widx]   <= n_per;
      sst_r[widx]    <= n_st;
      sivl_r[widx]   <= n_ivl;
      sstart_r[widx] <= n_start;
      srem_r[widx]   <= n_rem;
      sfires_r[widx] <= n_fires;
    end else if (cmd.fire) begin
      sst_r[ptr_r]    <= f_st;
      sstart_r[ptr_r] <= f_start;
      srem_r[ptr_r]   <= '0;
      sfires_r[ptr_r] <= f_fires;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.exec || cmd.fire || cmd.summary) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
    if (cmd.exec) begin
      o_status_r <= ex_status;
      o_slot_r   <= ex_slot;
      o_fired_r  <= 1'b0;
      o_nfired_r <= '0;
      o_tstate_r <= ex_qst;
      o_rem_r    <= ex_qrem;
      o_tfires_r <= ex_qfires;
      o_afires_r <= tot_fires_r;
      o_aticks_r <= tot_ticks_r;
      o_used_r   <= used_cnt;
      o_last_r   <= 1'b1;
    end else if (cmd.fire) begin
      o_status_r <= mctt_pkg::E_OK;
      o_slot_r   <= 8'(ptr_r);
      o_fired_r  <= 1'b1;
      o_nfired_r <= '0;
      o_tstate_r <= mctt_pkg::TS_STOPPED;
      o_rem_r    <= '0;
      o_tfires_r <= f_fires;
      o_afires_r <= tf_nxt;
      o_aticks_r <= tot_ticks_r;
      o_used_r   <= used_cnt;
      o_last_r   <= 1'b0;
    end else if (cmd.summary) begin
      o_status_r <= mctt_pkg::E_OK;
      o_slot_r   <= '0;
      o_fired_r  <= 1'b0;
      o_nfired_r <= fcnt_r;
      o_tstate_r <= mctt_pkg::TS_STOPPED;
      o_rem_r    <= '0;
      o_tfires_r <= '0;
      o_afires_r <= tot_fires_r;
      o_aticks_r <= tot_ticks_r + 32'd1;
      o_used_r   <= used_cnt;
      o_last_r   <= 1'b1;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = o_status_r;
  assign out_slot_id       = o_slot_r;
  assign out_fired         = o_fired_r;
  assign out_fired_in_tick = o_nfired_r;
  assign out_timer_state   = o_tstate_r;
  assign out_remaining     = o_rem_r;
  assign out_timer_fires   = o_tfires_r;
  assign out_all_fires     = o_afires_r;
  assign out_all_ticks     = o_aticks_r;
  assign out_used_slots    = o_used_r;
  assign out_last          = o_last_r;

  // a tick never reports more fires than there are slots
  `MCTT_ASSERT(a_fcnt_bound, clk, rst_n, fcnt_r <= CW'(N), "fire count exceeds slot count")
  // the summary result closes the tick
  `MCTT_ASSERT(a_sum_last, clk, rst_n, cmd.summary |=> (out_valid && out_last && !out_fired), "summary not marked last")

endmodule

// ===== sv/mctt_ctrl.sv =====
// Controller: sequences one transaction at a time through exec or the tick scan.
// Depends on mctt_pkg and the assertion macro header.
`include "multi_channel_soft_timer_table_macros.svh"
module mctt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mctt_pkg::sts_t sts,
  output mctt_pkg::cmd_t cmd
);

  mctt_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mctt_pkg::S_IDLE: if (in_valid) state_nxt = mctt_pkg::S_EXEC;
      mctt_pkg::S_EXEC: begin
        if (sts.is_tick)      state_nxt = mctt_pkg::S_SCAN;
        else if (sts.out_free) state_nxt = mctt_pkg::S_IDLE;
      end
      mctt_pkg::S_SCAN: begin
        if (sts.hit)           state_nxt = sts.need_div ? mctt_pkg::S_DIV : mctt_pkg::S_FIRE;
        else if (sts.ptr_last) state_nxt = mctt_pkg::S_SUM;
      end
      mctt_pkg::S_DIV: if (sts.div_done) state_nxt = mctt_pkg::S_FIRE;
      mctt_pkg::S_FIRE: begin
        if (sts.out_free) state_nxt = sts.ptr_last ? mctt_pkg::S_SUM : mctt_pkg::S_SCAN;
      end
      mctt_pkg::S_SUM: if (sts.out_free) state_nxt = mctt_pkg::S_IDLE;
      default: state_nxt = mctt_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != mctt_pkg::S_IDLE);
    case (state_r)
      mctt_pkg::S_IDLE: cmd.load = in_valid;
      mctt_pkg::S_EXEC: cmd.exec = !sts.is_tick && sts.out_free;
      mctt_pkg::S_SCAN: begin
        cmd.div_start = sts.hit && sts.need_div;
        cmd.ptr_inc   = !sts.hit && !sts.ptr_last;
      end
      mctt_pkg::S_DIV: cmd = '0;
      mctt_pkg::S_FIRE: begin
        cmd.fire    = sts.out_free;
        cmd.ptr_inc = sts.out_free && !sts.ptr_last;
      end
      mctt_pkg::S_SUM: cmd.summary = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mctt_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // results are only written into a free result register
  `MCTT_ASSERT(a_out_free, clk, rst_n, (cmd.exec || cmd.fire || cmd.summary) |-> sts.out_free, "result overwritten")
  // a divider launch is always followed by the wait for it
  `MCTT_ASSERT(a_div_wait, clk, rst_n, cmd.div_start |=> (state_r == mctt_pkg::S_DIV), "divider launch without wait")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for multi_channel_soft_timer_table: directed and random timer actions.
// Depends on mctt_pkg and the timer table RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_id;
    logic        fired;
    logic [5:0]  fired_in_tick;
    logic [1:0]  timer_state;
    logic [31:0] remaining;
    logic [31:0] timer_fires;
    logic [31:0] all_fires;
    logic [31:0] all_ticks;
    logic [5:0]  used_slots;
    logic        last;
  } timer_result_t;

  // Predicts the table state and keeps the results still owed by the block
  class timer_scoreboard;
    bit          used [mctt_pkg::NUM_TIMERS];
    bit          per [mctt_pkg::NUM_TIMERS];
    logic [1:0]  tstate [mctt_pkg::NUM_TIMERS];
    logic [31:0] ivl [mctt_pkg::NUM_TIMERS];
    logic [31:0] start [mctt_pkg::NUM_TIMERS];
    logic [31:0] rem [mctt_pkg::NUM_TIMERS];
    logic [31:0] fires [mctt_pkg::NUM_TIMERS];
    logic [31:0] tot_fires;
    logic [31:0] tot_ticks;
    timer_result_t pending_results[$];
    int mismatches;
    int checked;
    int fire_results;

    function new();
      for (int i = 0; i < mctt_pkg::NUM_TIMERS; i++) clear_slot(i);
      tot_fires = 0;
      tot_ticks = 0;
      mismatches = 0;
      checked = 0;
      fire_results = 0;
    endfunction

    function void clear_slot(int i);
      used[i] = 0; per[i] = 0; tstate[i] = mctt_pkg::TS_STOPPED;
      ivl[i] = 0; start[i] = 0; rem[i] = 0; fires[i] = 0;
    endfunction

    function logic [5:0] used_count();
      logic [5:0] n;
      n = 0;
      for (int i = 0; i < mctt_pkg::NUM_TIMERS; i++) n += 6'(used[i]);
      return n;
    endfunction

    function void push(logic [1:0] st, logic [7:0] sid, bit f, logic [5:0] nf,
                       logic [1:0] ts, logic [31:0] rm, logic [31:0] tf, bit lst);
      timer_result_t r;
      r.status = st; r.slot_id = sid; r.fired = f; r.fired_in_tick = nf;
      r.timer_state = ts; r.remaining = rm; r.timer_fires = tf;
      r.all_fires = tot_fires; r.all_ticks = tot_ticks;
      r.used_slots = used_count(); r.last = lst;
      pending_results.push_back(r);
    endfunction

    function logic [31:0] time_left(int k, logic [31:0] now);
      logic [31:0] el;
      if (tstate[k] == mctt_pkg::TS_PAUSED) return rem[k];
      if (tstate[k] != mctt_pkg::TS_RUNNING) return 0;
      el = now - start[k];
      return (el >= ivl[k]) ? 32'd0 : ivl[k] - el;
    endfunction

    // Noted once per accepted input transaction
    function void note_input(logic [3:0] act, logic [7:0] id, logic [31:0] iv,
                             bit pf, logic [31:0] now);
      logic [31:0] el;
      logic [5:0] n;
      int k;
      bit ok;
      k = id % mctt_pkg::NUM_TIMERS;
      ok = (id < mctt_pkg::NUM_TIMERS) && used[k];
      if (act == mctt_pkg::ACT_TICK) begin
        n = 0;
        for (int i = 0; i < mctt_pkg::NUM_TIMERS; i++) begin
          if (!used[i] || tstate[i] != mctt_pkg::TS_RUNNING) continue;
          el = now - start[i];
          if (el < ivl[i]) continue;
          fires[i]++;
          tot_fires++;
          if (!per[i]) tstate[i] = mctt_pkg::TS_STOPPED;
          else if (ivl[i] != 0) start[i] += (el / ivl[i]) * ivl[i];
          rem[i] = 0;
          push(mctt_pkg::E_OK, 8'(i), 1, 0, 0, 0, fires[i], 0);
          n++;
        end
        tot_ticks++;
        push(mctt_pkg::E_OK, 0, 0, n, 0, 0, 0, 1);
        return;
      end
      if (act == mctt_pkg::ACT_CREATE) begin
        if (iv == 0) begin
          push(mctt_pkg::E_INVALID, 0, 0, 0, 0, 0, 0, 1);
          return;
        end
        for (int i = 0; i < mctt_pkg::NUM_TIMERS; i++) begin
          if (used[i]) continue;
          clear_slot(i);
          used[i] = 1; per[i] = pf; ivl[i] = iv;
          push(mctt_pkg::E_OK, 8'(i), 0, 0, 0, 0, 0, 1);
          return;
        end
        push(mctt_pkg::E_FULL, 0, 0, 0, 0, 0, 0, 1);
        return;
      end
      if (act > mctt_pkg::ACT_QUERY) begin
        push(mctt_pkg::E_INVALID, id, 0, 0, 0, 0, 0, 1);
        return;
      end
      if (!ok) begin
        push(mctt_pkg::E_NOTFOUND, id, 0, 0, 0, 0, 0, 1);
        return;
      end
      case (act)
        mctt_pkg::ACT_DESTROY: clear_slot(k);
        mctt_pkg::ACT_START: begin
          start[k] = now; rem[k] = 0; tstate[k] = mctt_pkg::TS_RUNNING;
        end
        mctt_pkg::ACT_STOP: begin
          tstate[k] = mctt_pkg::TS_STOPPED; rem[k] = 0;
        end
        mctt_pkg::ACT_PAUSE: begin
          if (tstate[k] != mctt_pkg::TS_RUNNING) begin
            push(mctt_pkg::E_INVALID, id, 0, 0, 0, 0, 0, 1);
            return;
          end
          rem[k] = time_left(k, now);
          tstate[k] = mctt_pkg::TS_PAUSED;
        end
        mctt_pkg::ACT_RESUME: begin
          if (tstate[k] != mctt_pkg::TS_PAUSED) begin
            push(mctt_pkg::E_INVALID, id, 0, 0, 0, 0, 0, 1);
            return;
          end
          start[k] = now - (ivl[k] - rem[k]);
          tstate[k] = mctt_pkg::TS_RUNNING;
        end
        mctt_pkg::ACT_SETIVL: begin
          if (iv == 0) begin
            push(mctt_pkg::E_INVALID, id, 0, 0, 0, 0, 0, 1);
            return;
          end
          ivl[k] = iv;
          if (tstate[k] == mctt_pkg::TS_RUNNING) begin
            start[k] = now; rem[k] = 0;
          end else if (tstate[k] == mctt_pkg::TS_PAUSED) rem[k] = iv;
          else rem[k] = 0;
        end
        default: begin
          push(mctt_pkg::E_OK, id, 0, 0, tstate[k], time_left(k, now), fires[k], 1);
          return;
        end
      endcase
      push(mctt_pkg::E_OK, id, 0, 0, 0, 0, 0, 1);
    endfunction

    // Compares one accepted result with the oldest prediction
    function void check_result(timer_result_t got);
      timer_result_t exp_r;
      checked++;
      if (got.fired) fire_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d mismatch\n  exp %p\n  got %p", checked, exp_r, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [3:0]  in_action = 0;
  logic [7:0]  in_timer_id = 0;
  logic [31:0] in_interval = 0;
  logic        in_periodic = 0;
  logic [31:0] in_now = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [1:0]  out_status;
  logic [7:0]  out_slot_id;
  logic        out_fired;
  logic [5:0]  out_fired_in_tick;
  logic [1:0]  out_timer_state;
  logic [31:0] out_remaining;
  logic [31:0] out_timer_fires;
  logic [31:0] out_all_fires;
  logic [31:0] out_all_ticks;
  logic [5:0]  out_used_slots;
  logic        out_last;

  multi_channel_soft_timer_table DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  timer_scoreboard sb = new();
  logic [31:0] clock_ms = 0;
  int  items_sent = 0;
  int  ticks_sent = 0;
  bit  hold_off = 0;
  bit  hold_done = 0;
  int  idle_cycles = 0;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one transaction and waits for its acceptance; valid stays up for a back-to-back one
  task automatic send_action(logic [3:0] act, logic [7:0] id, logic [31:0] iv, bit pf,
                             logic [31:0] now);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1;
    in_action   <= act;
    in_timer_id <= id;
    in_interval <= iv;
    in_periodic <= pf;
    in_now      <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(act, id, iv, pf, now);
    items_sent++;
    if (act == mctt_pkg::ACT_TICK) ticks_sent++;
  endtask

  // Small random intervals so timers fire often; sometimes zero, sometimes huge ones
  function automatic logic [31:0] rand_ivl();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 0;
    if (p < 80) return $urandom_range(1, 40);
    return $urandom();
  endfunction

  function automatic logic [7:0] rand_id();
    if ($urandom_range(0, 9) == 0) return 8'($urandom());
    return 8'($urandom_range(0, mctt_pkg::NUM_TIMERS - 1));
  endfunction

  // Result side: accepts with random stalls, plus one long hold-off on request
  initial begin
    int s;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_done = 1;
        hold_off = 0;
      end
      s = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (s > 0) begin
        out_stall <= 1;
        repeat (s) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_status, out_slot_id, out_fired, out_fired_in_tick,
                        out_timer_state, out_remaining, out_timer_fires, out_all_fires,
                        out_all_ticks, out_used_slots, out_last});
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("ERROR: watchdog expired");
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int p;
    logic [3:0] act;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: zero interval, full table, bad ids, state errors, wrap
    send_action(mctt_pkg::ACT_CREATE, 0, 0, 0, 0);
    send_action(mctt_pkg::ACT_CREATE, 0, 32'hFFFF_FFFF, 1, 0);
    for (int i = 1; i < mctt_pkg::NUM_TIMERS; i++)
      send_action(mctt_pkg::ACT_CREATE, 0, 32'(i * 3), 1'(i % 2), 0);
    send_action(mctt_pkg::ACT_CREATE, 0, 5, 0, 0);
    send_action(mctt_pkg::ACT_START, 8'hFF, 0, 0, 0);
    send_action(mctt_pkg::ACT_PAUSE, 1, 0, 0, 0);
    send_action(mctt_pkg::ACT_RESUME, 1, 0, 0, 0);
    send_action(4'hF, 8'hAA, 0, 0, 0);
    send_action(4'h9, 3, 0, 0, 0);
    for (int i = 1; i < mctt_pkg::NUM_TIMERS; i++)
      send_action(mctt_pkg::ACT_START, 8'(i), 0, 0, 32'hFFFF_FFF0);
    send_action(mctt_pkg::ACT_START, 0, 0, 0, 32'hFFFF_FFF0);
    send_action(mctt_pkg::ACT_SETIVL, 2, 0, 0, 0);
    send_action(mctt_pkg::ACT_TICK, 0, 0, 0, 32'h0000_0100);
    send_action(mctt_pkg::ACT_QUERY, 0, 0, 0, 32'h0000_0100);
    send_action(mctt_pkg::ACT_DESTROY, 7, 0, 0, 0);
    send_action(mctt_pkg::ACT_QUERY, 7, 0, 0, 0);
    send_action(mctt_pkg::ACT_STOP, 1, 0, 0, 0);

    // Receiver holds off while the sender keeps offering
    hold_off = 1;
    for (int i = 0; i < 6; i++)
      send_action(mctt_pkg::ACT_TICK, 0, 0, 0, 32'(32'h200 + i * 50));
    in_valid <= 0;
    wait (hold_done);

    // Random: mostly lifecycle on valid slots with time advancing
    clock_ms = $urandom();
    for (int n = 0; n < 340; n++) begin
      p = $urandom_range(0, 99);
      clock_ms += $urandom_range(0, 20);
      if (p < 30) act = mctt_pkg::ACT_TICK;
      else if (p < 40) act = mctt_pkg::ACT_CREATE;
      else if (p < 45) act = mctt_pkg::ACT_DESTROY;
      else if (p < 58) act = mctt_pkg::ACT_START;
      else if (p < 62) act = mctt_pkg::ACT_STOP;
      else if (p < 70) act = mctt_pkg::ACT_PAUSE;
      else if (p < 78) act = mctt_pkg::ACT_RESUME;
      else if (p < 84) act = mctt_pkg::ACT_SETIVL;
      else if (p < 97) act = mctt_pkg::ACT_QUERY;
      else act = 4'($urandom_range(9, 15));
      send_action(act, rand_id(), rand_ivl(), 1'($urandom_range(0, 1)), clock_ms);
    end
    in_valid <= 0;

    // Drain, then allow a full tick latency
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Ran %0d transactions (%0d ticks); checked %0d results, %0d timer fires.",
             items_sent, ticks_sent, sb.checked, sb.fire_results);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("Mismatches: %0d, results still owed: %0d",
               sb.mismatches, sb.pending_results.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
